FILE: sv/pfmf_pkg.sv
// ----------------------------------------------------------------------------
// pfmf_pkg
// Shared constants and types of the pattern first-match finder.
// ----------------------------------------------------------------------------
package pfmf_pkg;

	// Number of pattern cells, 1 to 16.
	localparam int PATTERN_MAX = 16;
	// Width of the running text index, 8 to 32.
	localparam int INDEX_BITS  = 20;

	// Fixed field widths.
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 5;
	localparam int START_W = 20;
	localparam int WORD_W  = 64;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_TDATA_W = 24;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START    = 2'd3;

	// Per-transfer control broadcast to every cell.
	typedef struct packed {
		logic step;   // advance the prefix bit with the current byte
		logic clear;  // end of text: drop the prefix bit
	} cell_ctl_t;

	// One result item.
	typedef struct packed {
		logic               found;
		logic [START_W-1:0] match_start;
	} result_t;

endpackage

FILE: sv/pfmf_cell.sv
// ----------------------------------------------------------------------------
// pfmf_cell
// One pattern position: compares its pattern byte with the text byte and
// extends the prefix handed over by the previous cell.
// ----------------------------------------------------------------------------
module pfmf_cell import pfmf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic              enable,     // this position lies inside the pattern
	input  logic              prev_bit,   // prefix one byte shorter, from the left neighbor
	input  logic [BYTE_W-1:0] pat_byte,
	input  logic [BYTE_W-1:0] text_byte,
	output logic              nxt_bit,    // value after the current byte
	output logic              bit_q       // prefix held, handed to the right neighbor
);

	assign nxt_bit = prev_bit & enable & (pat_byte == text_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctl.clear) begin
			bit_q <= 1'b0;
		end else if (ctl.step) begin
			bit_q <= nxt_bit;
		end
	end

endmodule

FILE: sv/pattern_first_match_finder.sv
// ----------------------------------------------------------------------------
// pattern_first_match_finder
// Streaming search for the first occurrence of a pattern of up to 16 bytes.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock cycle on the slave stream, with
// tlast marking the final byte of a text, and gives at most one result per
// text on the master stream: tuser high with the start index of the first
// match in tdata, or tuser low with a zero index when the text ended without
// a match. Each byte is handled in the cycle it is transferred: a row of
// pattern cells, one per pattern position, each keeps one bit saying that the
// pattern prefix up to its position ends at the latest byte, and passes that
// bit to its right neighbor every cycle. The pattern is therefore matched in
// one pass with no backtracking, and the sustained rate is one byte per cycle
// while tready is high; the result for the byte that completes the match (or
// the last byte) is registered. Results go into a two-entry output buffer,
// so the slave side keeps taking bytes while one result waits; tready drops
// only while both entries are full. Bytes after the first match of a text are
// taken and ignored until its last byte. The text index starts at
// start_offset for each text and wraps modulo 2^INDEX_BITS. Configuration is
// written through cfg_we, cfg_index and cfg_wdata while the block is idle; a
// pattern length of zero acts as one and a length above 16 acts as 16.
// ----------------------------------------------------------------------------
module pattern_first_match_finder import pfmf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,

	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [WORD_W-1:0]      cfg_wdata,

	// Text stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [BYTE_W-1:0]      s_tdata,    // [7:0] text_byte
	input  logic                   s_tlast,    // last_byte

	// Result stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,    // [19:0] match_start, [23:20] zero
	output logic                   m_tuser     // [0] found
);

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [WORD_W-1:0]  pat_low_q;
	logic [WORD_W-1:0]  pat_high_q;
	logic [LEN_W-1:0]   pat_len_q;
	logic [START_W-1:0] start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= LEN_W'(1);
			start_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAT_LOW:  pat_low_q  <= cfg_wdata;
				REG_PAT_HIGH: pat_high_q <= cfg_wdata;
				REG_PAT_LEN:  pat_len_q  <= cfg_wdata[LEN_W-1:0];
				REG_START:    start_q    <= cfg_wdata[START_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective length, clamped to the number of cells.
	logic [LEN_W-1:0] len_eff;

	always_comb begin
		if (pat_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (pat_len_q > LEN_W'(PATTERN_MAX)) begin
			len_eff = LEN_W'(PATTERN_MAX);
		end else begin
			len_eff = pat_len_q;
		end
	end

	logic [2*WORD_W-1:0] pat_word;
	assign pat_word = {pat_high_q, pat_low_q};

	// ------------------------------------------------------------------
	// Text state.
	// ------------------------------------------------------------------
	logic                  accept;
	logic                  done_q;
	logic                  in_text_q;
	logic [INDEX_BITS-1:0] pos_q;
	cell_ctl_t             ctl;

	assign accept    = s_tvalid & s_tready;
	assign ctl.step  = accept & ~done_q;
	assign ctl.clear = accept & s_tlast;

	// ------------------------------------------------------------------
	// Cell row. Cell k holds "pattern bytes 0..k end at the latest byte".
	// The first cell always has an empty prefix to extend.
	// ------------------------------------------------------------------
	logic [PATTERN_MAX-1:0] held;
	logic [PATTERN_MAX-1:0] nxt;
	logic [PATTERN_MAX-1:0] tail_sel;   // one-hot on the last pattern position

	genvar k;
	generate
		for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
			logic prev;
			if (k == 0) begin : g_head
				assign prev = 1'b1;
			end else begin : g_link
				assign prev = held[k-1];
			end

			assign tail_sel[k] = (len_eff == LEN_W'(k + 1));

			pfmf_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.enable    (LEN_W'(k) < len_eff),
				.prev_bit  (prev),
				.pat_byte  (pat_word[BYTE_W*k +: BYTE_W]),
				.text_byte (s_tdata),
				.nxt_bit   (nxt[k]),
				.bit_q     (held[k])
			);
		end
	endgenerate

	// A full match appears when the last pattern position turns on.
	logic                  hit;
	logic                  push;
	logic [INDEX_BITS-1:0] start_idx;
	result_t               push_res;

	assign hit       = ctl.step & (|(nxt & tail_sel));
	assign push      = hit | (ctl.clear & ~done_q);
	assign start_idx = pos_q - INDEX_BITS'(len_eff - LEN_W'(1));

	always_comb begin
		push_res.found       = hit;
		push_res.match_start = hit ? START_W'(start_idx) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			in_text_q <= 1'b0;
			pos_q     <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				done_q    <= 1'b0;
				in_text_q <= 1'b0;
				pos_q     <= INDEX_BITS'(start_q);
			end else begin
				done_q    <= done_q | hit;
				in_text_q <= 1'b1;
				pos_q     <= pos_q + INDEX_BITS'(1);
			end
		end else if (cfg_we && cfg_index == REG_START && !in_text_q) begin
			// A new start offset takes effect at once between texts.
			pos_q <= INDEX_BITS'(cfg_wdata[START_W-1:0]);
		end
	end

	// ------------------------------------------------------------------
	// Two-entry output buffer: the output register and a skid entry.
	// A result goes to the skid entry only when the output register is
	// occupied and not being drained.
	// ------------------------------------------------------------------
	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop      = out_valid_q & m_tready;
	assign s_tready = ~skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : push_res;
		end
		if (push && out_valid_q && !pop) begin
			skid_q <= push_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.found;
	assign m_tdata  = OUT_TDATA_W'(out_q.match_start);

endmodule

FILE: sv/pfmf_checker.sv
// ----------------------------------------------------------------------------
// pfmf_checker
// Port-level assertions for the pattern first-match finder.
// ----------------------------------------------------------------------------
module pfmf_checker import pfmf_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser
);

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A not-found result carries a zero index.
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("not-found result with nonzero index");

	// The text side stalls only while a result is waiting.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("text side stalled with no result pending");

	// Without a transfer on the text side, no new result appears.
	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
		else $error("result appeared without a text transfer");

endmodule

bind pattern_first_match_finder pfmf_checker u_pfmf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
